### hw/rtl/gfsr521_pkg.sv
// gfsr521_pkg: constants, state type and control structs of the gfsr random generator
// used by gfsr521_lcg and gfsr_random_generator_521_core; no dependencies
package gfsr521_pkg;

	localparam int unsigned TABLE_WORDS = 521;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned LAG         = 32;
	localparam int unsigned SEED_WORDS  = 17;
	localparam int unsigned SHIFT_L     = 23;
	localparam int unsigned SHIFT_R     = 9;
	localparam int unsigned BIT_W       = $clog2(WORD_W);
	localparam int unsigned PASS_W      = 2;

	localparam logic [WORD_W-1:0] LCG_MUL = 32'd1566083941;
	localparam logic [WORD_W-1:0] LCG_INC = 32'd1;

	// recurrence taps in the window, newest word at index 0
	localparam int unsigned TAP_NEAR = 0;
	localparam int unsigned TAP_MID  = SEED_WORDS - 2;
	localparam int unsigned TAP_FAR  = SEED_WORDS - 1;

	localparam logic [PASS_W-1:0] PASS_LAST = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LCG,
		ST_FILL,
		ST_MIX,
		ST_WRAP_RD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic run;
	} lcg_ctrl_t;

	typedef struct packed {
		logic              word_done;
		logic [WORD_W-1:0] word;
	} lcg_stat_t;

endpackage

### hw/rtl/gfsr521_lcg.sv
// gfsr521_lcg: linear congruential sequence, one step a cycle while run is high, gathering top bits into words
// depends on gfsr521_pkg
module gfsr521_lcg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gfsr521_pkg::lcg_ctrl_t            ctrl,
	input  logic [gfsr521_pkg::WORD_W-1:0]    seed,
	output gfsr521_pkg::lcg_stat_t            stat
);
	import gfsr521_pkg::*;

	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] acc_q;
	logic [BIT_W-1:0]  bit_q;
	logic [WORD_W-1:0] x_next;
	logic [WORD_W-1:0] acc_next;

	assign x_next   = WORD_W'(x_q * LCG_MUL) + LCG_INC;
	assign acc_next = {x_next[WORD_W-1], acc_q[WORD_W-1:1]};

	always_comb begin
		stat.word_done = ctrl.run && (bit_q == BIT_W'(WORD_W - 1));
		stat.word      = acc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (ctrl.load) begin
			bit_q <= '0;
		end else if (ctrl.run) begin
			bit_q <= bit_q + BIT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= seed;
		end else if (ctrl.run) begin
			x_q   <= x_next;
			acc_q <= acc_next;
		end
	end

endmodule

### hw/rtl/gfsr_random_generator_521_core.sv
// gfsr_random_generator_521_core: top level of the 521-word gfsr random generator
// depends on gfsr521_pkg and gfsr521_lcg
//
// usage: a request is taken at a rising edge with start high and busy low.
// kind 0 reseeds from seed and gives no result; kind 1 asks for the next word.
// a result is shown on random_word for one cycle with done high; the receiver
// cannot stall, so the result is taken at the end of that cycle.
// next word: result in the cycle after the request; busy stays low while a
// result is shown, so one word per cycle is sustained until a request wraps.
// wrap: once seeded, the request that steps past the last word runs one shuffle
// pass over the table memory, one read-modify-write a cycle, and gives its result
// after the pass by reading word 0 in ST_WRAP_RD.
// reseed: busy through 544 sequence steps, 504 fill writes and four shuffle passes
// over the table; fill writes and shuffle write-backs share the single write port.
// reset: no clearing pass; until the first reseed every result reads as zero.
module gfsr_random_generator_521_core #(
	parameter int unsigned TableWords = gfsr521_pkg::TABLE_WORDS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           kind,
	input  logic [gfsr521_pkg::WORD_W-1:0] seed,
	output logic                           busy,
	output logic                           done,
	output logic [gfsr521_pkg::WORD_W-1:0] random_word
);
	import gfsr521_pkg::*;

	localparam int unsigned AddrW = $clog2(TableWords);
	localparam logic [AddrW-1:0] LastAddr = AddrW'(TableWords - 1);
	localparam logic [AddrW-1:0] SeedLast = AddrW'(SEED_WORDS - 1);

	state_t state_q, state_d;
	logic [AddrW-1:0]  cnt_q, cnt_d;
	logic [PASS_W-1:0] pass_q, pass_d;
	logic              wrap_q, wrap_d;
	logic [AddrW-1:0]  pos_q, pos_d;
	logic              consumed_q, consumed_d;
	logic              seeded_q, seeded_d;

	logic [WORD_W-1:0] mem [TableWords];
	logic [WORD_W-1:0] rdata_q;
	logic              rd_en;
	logic [AddrW-1:0]  raddr;
	logic              we;
	logic [AddrW-1:0]  waddr;
	logic [WORD_W-1:0] wdata;

	logic              fill_we;
	logic [AddrW-1:0]  fill_addr;
	logic [WORD_W-1:0] fill_data;

	logic [WORD_W-1:0] win_q [LAG];

	logic              mix_vld_s1;
	logic [AddrW-1:0]  mix_addr_s1;

	logic              accept;
	logic [WORD_W-1:0] fill_val;
	logic [WORD_W-1:0] redo_val;

	lcg_ctrl_t lcg_ctrl;
	lcg_stat_t lcg_stat;

	gfsr521_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lcg_ctrl),
		.seed   (seed),
		.stat   (lcg_stat)
	);

	assign busy        = !(state_q == ST_IDLE || state_q == ST_OUT);
	assign done        = (state_q == ST_OUT);
	assign accept      = start && !busy;
	assign random_word = seeded_q ? rdata_q : '0;

	assign fill_val = win_q[TAP_NEAR] ^ (win_q[TAP_MID] >> SHIFT_R)
	                ^ (win_q[TAP_FAR] << SHIFT_L);
	assign redo_val = win_q[TAP_NEAR] ^ (win_q[TAP_MID] >> SHIFT_R)
	                ^ (lcg_stat.word << SHIFT_L);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		pass_d     = pass_q;
		wrap_d     = wrap_q;
		pos_d      = pos_q;
		consumed_d = consumed_q;
		seeded_d   = seeded_q;
		rd_en      = 1'b0;
		raddr      = pos_q;
		fill_we    = 1'b0;
		fill_addr  = cnt_q;
		fill_data  = fill_val;
		lcg_ctrl   = '0;
		case (state_q)
			ST_IDLE, ST_OUT: begin
				state_d = ST_IDLE;
				if (accept) begin
					if (!kind) begin
						lcg_ctrl.load = 1'b1;
						seeded_d      = 1'b1;
						pos_d         = '0;
						consumed_d    = 1'b0;
						cnt_d         = '0;
						state_d       = ST_LCG;
					end else begin
						consumed_d = 1'b1;
						state_d    = ST_OUT;
						if (!consumed_q) begin
							rd_en = 1'b1;
							raddr = pos_q;
						end else if (pos_q == LastAddr) begin
							pos_d = '0;
							if (seeded_q) begin
								state_d = ST_MIX;
								cnt_d   = '0;
								wrap_d  = 1'b1;
							end
						end else begin
							pos_d = pos_q + AddrW'(1);
							rd_en = 1'b1;
							raddr = pos_q + AddrW'(1);
						end
					end
				end
			end
			ST_LCG: begin
				lcg_ctrl.run = 1'b1;
				if (lcg_stat.word_done) begin
					fill_we = 1'b1;
					cnt_d   = cnt_q + AddrW'(1);
					if (cnt_q == SeedLast) begin
						fill_data = redo_val;
						state_d   = ST_FILL;
					end else begin
						fill_data = lcg_stat.word;
					end
				end
			end
			ST_FILL: begin
				fill_we = 1'b1;
				if (cnt_q == LastAddr) begin
					cnt_d   = '0;
					pass_d  = '0;
					wrap_d  = 1'b0;
					state_d = ST_MIX;
				end else begin
					cnt_d = cnt_q + AddrW'(1);
				end
			end
			ST_MIX: begin
				rd_en = 1'b1;
				raddr = cnt_q;
				if (cnt_q == LastAddr) begin
					cnt_d = '0;
					if (wrap_q) begin
						state_d = ST_WRAP_RD;
					end else if (pass_q == PASS_LAST) begin
						state_d = ST_IDLE;
					end else begin
						pass_d = pass_q + PASS_W'(1);
					end
				end else begin
					cnt_d = cnt_q + AddrW'(1);
				end
			end
			ST_WRAP_RD: begin
				rd_en   = 1'b1;
				raddr   = '0;
				state_d = ST_OUT;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// shuffle write-back takes the port; fill and shuffle never overlap
	always_comb begin
		if (mix_vld_s1) begin
			we    = 1'b1;
			waddr = mix_addr_s1;
			wdata = rdata_q ^ win_q[LAG-1];
		end else begin
			we    = fill_we;
			waddr = fill_addr;
			wdata = fill_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pass_q     <= '0;
			wrap_q     <= 1'b0;
			pos_q      <= '0;
			consumed_q <= 1'b1;
			seeded_q   <= 1'b0;
			mix_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			pass_q     <= pass_d;
			wrap_q     <= wrap_d;
			pos_q      <= pos_d;
			consumed_q <= consumed_d;
			seeded_q   <= seeded_d;
			mix_vld_s1 <= (state_q == ST_MIX);
		end
	end

	always_ff @(posedge clk) begin
		mix_addr_s1 <= cnt_q;
	end

	// table memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// window of the last words written, in table order
	always_ff @(posedge clk) begin
		if (we) begin
			win_q[0] <= wdata;
			for (int i = 1; i < LAG; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

endmodule

### hw/rtl/gfsr521_checker.sv
// gfsr521_checker: port-level assertions on the gfsr random generator, with its bind
// depends on gfsr_random_generator_521_core
module gfsr521_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic kind,
	input logic busy,
	input logic done
);

	// a reseed request always makes the block busy
	a_seed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !kind) |=> busy)
		else $error("reseed request did not raise busy");

	// a reseed request gives no result
	a_seed_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !kind) |=> !done)
		else $error("result after reseed request");

	// a result is only shown while new requests can be taken
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// a next request that leaves the block free gives its result in the next cycle
	a_next_done: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && $past(start && !busy && kind) && !busy) |-> done)
		else $error("missing result after next request");

	// busy only rises on a request
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && $rose(busy)) |-> $past(start))
		else $error("busy rose without request");

endmodule

bind gfsr_random_generator_521_core gfsr521_checker u_gfsr521_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.kind   (kind),
	.busy   (busy),
	.done   (done)
);
